// ===== sv/zci_pkg.sv =====
// Shared types and constants for the zero-crossing interpolator.
package zci_pkg;

  localparam int unsigned SampleWidthDef  = 32;
  localparam int unsigned FractionBitsDef = 16;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SLOPE_ENABLE = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD_Z,
    ST_DIV_Z,
    ST_FIN_Z,
    ST_LOAD_S,
    ST_DIV_S,
    ST_DONE
  } state_e;

endpackage

// ===== sv/zero_crossing_interpolator.sv =====
// Zero-crossing interpolator for one column of (x, y) samples, top level.
//
// The block takes one (x, y) word at a time, adds the configured level offset
// to y, and compares it with the word held from before. When the offset y
// values touch or change sign between the two words, one result word gives
// the interpolated x where the line through them crosses zero, the slope
// dy/dx when slope_enable is set, and the crossing level -level_offset.
// A word flagged page_start, or the first word after reset, is only stored.
// A word that causes no result leaves the block idle, so the next word can
// follow right away. A crossing that is a special case (equal x values, or
// both offset y values zero) goes straight to the result. A general crossing
// runs a multiply step, then one radix-2 restoring divider shared by the
// position and slope quotients, each needing SAMPLE_WIDTH+1 subtract steps.
// With slope disabled the second division is skipped. When the slope is too
// steep for the quotient register it is clamped at once and the second
// division is skipped as well. Any crossing takes longer while the output
// register still holds a result that has not been read.
// The input is not ready while a word is in work; a finished result waits in
// an output register so the next word can be taken before it is consumed.
// Configuration is written through a plain write port with no wait states and
// must only change while the block idles.
module zero_crossing_interpolator
  import zci_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH  = SampleWidthDef,
  parameter int unsigned FRACTION_BITS = FractionBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [CfgIdxW-1:0]             cfg_index_i,
  input  logic [SAMPLE_WIDTH-1:0]        cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] y_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_sample_i,
  input  logic                           page_start_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] zero_position_o,
  output logic signed [SAMPLE_WIDTH-1:0] slope_value_o,
  output logic                           slope_infinite_o,
  output logic signed [SAMPLE_WIDTH-1:0] crossing_level_o
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  // Quotient width: the position quotient never exceeds 2^W.
  localparam int unsigned QW = W + 1;
  // Divisor width: |dy| stays below 2^(W+1).
  localparam int unsigned DW = W + 2;
  // Numerator width covers both the product and the shifted |dy|.
  localparam int unsigned NW = (2 * W + 2 > W + 2 + F) ? 2 * W + 2 : W + 2 + F;
  localparam int unsigned CW = $clog2(QW);

  localparam logic [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};

  // Configuration registers.
  logic signed [W-1:0] level_offset_q;
  logic                slope_enable_q;

  // Held sample from the previous word.
  logic signed [W:0]   prev_y_q;
  logic signed [W-1:0] prev_x_q;
  logic                have_prev_q;

  // Per-crossing operands captured at accept time, and their product.
  logic signed [W-1:0] xp_q;
  logic [W:0]          mag_yp_q;
  logic [W:0]          mag_dx_q;
  logic [DW-1:0]       mag_dy_q;
  logic                neg_z_q;
  logic                neg_s_q;
  logic [2*W+1:0]      prod_q;

  // Shared divider.
  logic [DW-1:0]       rem_q;
  logic [QW-1:0]       lo_q;
  logic [QW-1:0]       quo_q;
  logic [DW-1:0]       dvs_q;
  logic [CW-1:0]       cnt_q;

  // Pending result. The slope comes from the divider only when its division ran.
  logic signed [W-1:0] res_zero_q;
  logic signed [W-1:0] res_slope_q;
  logic                res_inf_q;
  logic                slope_div_q;

  // Output register.
  logic                out_valid_q;
  logic signed [W-1:0] out_zero_q;
  logic signed [W-1:0] out_slope_q;
  logic                out_inf_q;
  logic signed [W-1:0] out_level_q;

  state_e state_q, state_d;

  // ---------------------------------------------------------------------
  // Accept-time arithmetic: offset add, pair compare and the differences.
  // ---------------------------------------------------------------------
  logic              in_fire;
  logic signed [W:0] cur_y;
  logic signed [W:0] dx_w;
  logic signed [W+1:0] dy_w;
  logic signed [W:0] xsum_w;
  logic signed [W:0] mid_w;
  logic              fresh;
  logic              crossing;
  logic              dx_zero;
  logic              dy_zero;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cur_y    = $signed({y_sample_i[W-1], y_sample_i})
             + $signed({level_offset_q[W-1], level_offset_q});
    dx_w     = $signed({x_sample_i[W-1], x_sample_i}) - $signed({prev_x_q[W-1], prev_x_q});
    dy_w     = $signed({cur_y[W], cur_y}) - $signed({prev_y_q[W], prev_y_q});
    xsum_w   = $signed({x_sample_i[W-1], x_sample_i}) + $signed({prev_x_q[W-1], prev_x_q});
    // Halving truncates toward zero: a negative sum is bumped up by one first.
    mid_w    = xsum_w + $signed({{W{1'b0}}, xsum_w[W]});
    fresh    = page_start_i || !have_prev_q;
    crossing = ((prev_y_q <= 0) && (cur_y >= 0)) || ((prev_y_q >= 0) && (cur_y <= 0));
    dx_zero  = (dx_w == '0);
    dy_zero  = (dy_w == '0);
  end

  // ---------------------------------------------------------------------
  // Divider step and the quotient post-processing.
  // ---------------------------------------------------------------------
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_diff;
  logic            rem_ge;
  logic [NW-1:0]   num_z;
  logic [NW-1:0]   num_s;
  logic [NW-1:0]   num_s_hi;
  logic            slope_ovf;
  logic signed [W+1:0] zero_term;
  logic signed [W+1:0] zero_diff;
  logic signed [W-1:0] zero_sat;
  logic signed [W-1:0] slope_sat;
  logic signed [W-1:0] level_neg;

  always_comb begin
    rem_sh    = {rem_q, lo_q[QW-1]};
    rem_diff  = rem_sh - {1'b0, dvs_q};
    rem_ge    = !rem_diff[DW];

    num_z     = NW'(prod_q);
    num_s     = NW'(mag_dy_q) << F;
    num_s_hi  = num_s >> QW;
    slope_ovf = (num_s_hi >= NW'(mag_dx_q));

    zero_term = neg_z_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    zero_diff = $signed({{2{xp_q[W-1]}}, xp_q}) - zero_term;
    if ((zero_diff[W+1:W-1] == 3'b000) || (zero_diff[W+1:W-1] == 3'b111)) begin
      zero_sat = zero_diff[W-1:0];
    end else if (zero_diff[W+1]) begin
      zero_sat = SMIN;
    end else begin
      zero_sat = SMAX;
    end

    // Slope magnitude to signed, clamped at the ends of the range.
    if (neg_s_q) begin
      if (quo_q[W] || (quo_q[W-1] && (quo_q[W-2:0] != '0))) begin
        slope_sat = SMIN;
      end else begin
        slope_sat = -$signed(quo_q[W-1:0]);
      end
    end else begin
      if (quo_q[W] || quo_q[W-1]) begin
        slope_sat = SMAX;
      end else begin
        slope_sat = quo_q[W-1:0];
      end
    end

    // Negating the most negative offset clamps to the maximum.
    level_neg = (level_offset_q == SMIN) ? SMAX : -level_offset_q;
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  logic out_load;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !fresh && crossing) begin
          if (dx_zero || dy_zero) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:    state_d = ST_LOAD_Z;
      ST_LOAD_Z: state_d = ST_DIV_Z;
      ST_DIV_Z: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN_Z;
        end
      end
      ST_FIN_Z: begin
        state_d = slope_enable_q ? ST_LOAD_S : ST_DONE;
      end
      ST_LOAD_S: begin
        state_d = slope_ovf ? ST_DONE : ST_DIV_S;
      end
      ST_DIV_S: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: configuration, held sample and its flag, and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_offset_q <= '0;
      slope_enable_q <= 1'b0;
      prev_y_q       <= '0;
      prev_x_q       <= '0;
      have_prev_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LEVEL_OFFSET: level_offset_q <= cfg_data_i;
          CFG_SLOPE_ENABLE: slope_enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_y_q    <= cur_y;
        prev_x_q    <= x_sample_i;
        have_prev_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          xp_q     <= prev_x_q;
          mag_yp_q <= prev_y_q[W] ? -prev_y_q : prev_y_q;
          mag_dx_q <= dx_w[W] ? -dx_w : dx_w;
          mag_dy_q <= dy_w[W+1] ? -dy_w : dy_w;
          neg_z_q  <= prev_y_q[W] ^ dx_w[W] ^ dy_w[W+1];
          neg_s_q  <= dy_w[W+1] ^ dx_w[W];
          res_inf_q   <= 1'b0;
          res_slope_q <= '0;
          slope_div_q <= 1'b0;
          if (dx_zero) begin
            res_zero_q <= prev_x_q;
            if (slope_enable_q) begin
              res_slope_q <= SMAX;
              res_inf_q   <= 1'b1;
            end
          end else begin
            res_zero_q <= mid_w[W:1];
          end
        end
      end
      ST_MUL: begin
        prod_q <= mag_yp_q * mag_dx_q;
      end
      ST_LOAD_Z: begin
        rem_q <= DW'(num_z >> QW);
        lo_q  <= num_z[QW-1:0];
        dvs_q <= mag_dy_q;
        cnt_q <= CW'(QW - 1);
      end
      ST_DIV_Z, ST_DIV_S: begin
        rem_q <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
        lo_q  <= lo_q << 1;
        quo_q <= {quo_q[QW-2:0], rem_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_FIN_Z: begin
        res_zero_q <= zero_sat;
      end
      ST_LOAD_S: begin
        rem_q <= num_s_hi[DW-1:0];
        lo_q  <= num_s[QW-1:0];
        dvs_q <= DW'(mag_dx_q);
        cnt_q <= CW'(QW - 1);
        slope_div_q <= !slope_ovf;
        if (slope_ovf) begin
          res_slope_q <= neg_s_q ? SMIN : SMAX;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_zero_q  <= res_zero_q;
          out_slope_q <= slope_div_q ? slope_sat : res_slope_q;
          out_inf_q   <= res_inf_q;
          out_level_q <= level_neg;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign zero_position_o  = out_zero_q;
  assign slope_value_o    = out_slope_q;
  assign slope_infinite_o = out_inf_q;
  assign crossing_level_o = out_level_q;

endmodule
